### design/assert_macros.svh
// Assertion macros for the deframer RTL, included by cpd_parser.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on each rising clock edge, ignored while reset is held.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `ASSERT_PROP(lbl, clk, rst_n, !(expr))

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

### design/cpd_pkg.sv
// Shared constants, result type and ones-complement add for the deframer.
// No dependencies.
package cpd_pkg;

    localparam int DATA_BYTES = 1024;
    localparam int HEADER_LEN = 8;
    localparam int PACKET_LEN = HEADER_LEN + DATA_BYTES;
    localparam int POS_W      = 11;

    // Byte offsets within the packet header
    localparam logic [POS_W-1:0] POS_CK_LO    = POS_W'(0);
    localparam logic [POS_W-1:0] POS_CK_HI    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_ID_FIRST = POS_W'(2);
    localparam logic [POS_W-1:0] POS_ID_LAST  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_TOT_FIRST = POS_W'(5);
    localparam logic [POS_W-1:0] POS_TOT_LAST = POS_W'(7);
    localparam logic [POS_W-1:0] POS_PAYLOAD  = POS_W'(HEADER_LEN);
    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(PACKET_LEN - 1);

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        is_last;
        logic        checksum_ok;
        logic [23:0] packet_id;
        logic [23:0] packet_total;
    } result_t;

    // 16-bit add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

### design/cpd_in_stage.sv
// Input register of the deframer: holds one received byte for the parser.
// Depends on nothing beyond the port list.
module cpd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       hold_valid,
    output logic [7:0] hold_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    // Hold off the sender only when the held byte cannot move on
    assign rx_stall = valid_reg && !advance;
    assign take     = rx_valid && !rx_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

endmodule

### design/cpd_parser.sv
// Packet parser: byte position, header capture and ones-complement sum.
// Depends on cpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       byte_in,
    output logic             res_valid,
    output cpd_pkg::result_t res
);

    import cpd_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      sum_reg, sum_next;
    logic [15:0]      chk_reg, chk_next;
    logic [23:0]      id_reg, id_next;
    logic [23:0]      tot_reg, tot_next;
    logic [7:0]       pend_reg, pend_next;
    logic [15:0]      sum_after;
    logic             last;

    assign last = (pos_reg == POS_LAST);

    always_comb
    begin
        sum_after = sum_reg;
        if ((pos_reg != POS_CK_LO) && (pos_reg != POS_CK_HI))
        begin
            if (!pos_reg[0])
            begin
                // Odd trailing byte goes in as the low byte
                if (last)
                begin
                    sum_after = oc_add(sum_reg, {8'h00, byte_in});
                end
            end
            else
            begin
                sum_after = oc_add(sum_reg, {byte_in, pend_reg});
            end
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        chk_next  = chk_reg;
        id_next   = id_reg;
        tot_next  = tot_reg;
        pend_next = pend_reg;
        if (step)
        begin
            if (pos_reg == POS_CK_LO)
            begin
                chk_next = {8'h00, byte_in};
            end
            else if (pos_reg == POS_CK_HI)
            begin
                chk_next = {byte_in, chk_reg[7:0]};
            end
            else
            begin
                if (!pos_reg[0])
                begin
                    pend_next = byte_in;
                end
                if ((pos_reg >= POS_ID_FIRST) && (pos_reg <= POS_ID_LAST))
                begin
                    id_next = {id_reg[15:0], byte_in};
                end
                else if ((pos_reg >= POS_TOT_FIRST) && (pos_reg <= POS_TOT_LAST))
                begin
                    tot_next = {tot_reg[15:0], byte_in};
                end
            end
            // Rewind for the next packet after the final byte
            if (last)
            begin
                pos_next = '0;
                sum_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                sum_next = sum_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            chk_reg  <= '0;
            id_reg   <= '0;
            tot_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            chk_reg  <= chk_next;
            id_reg   <= id_next;
            tot_reg  <= tot_next;
            pend_reg <= pend_next;
        end
    end

    assign res_valid          = (pos_reg >= POS_PAYLOAD);
    assign res.payload_byte   = byte_in;
    assign res.is_last        = last;
    assign res.checksum_ok    = last && ((~sum_after) == chk_reg);
    assign res.packet_id      = last ? id_reg : 24'd0;
    assign res.packet_total   = last ? tot_reg : 24'd0;

    `ASSERT_NEVER(a_pos_range, clk, rst_n, pos_reg > POS_LAST)
    `ASSERT_PROP(a_rewind, clk, rst_n, (step && last) |=> (pos_reg == '0) && (sum_reg == '0))
    `ASSERT_PROP(a_idle_hold, clk, rst_n, !step |=> $stable(pos_reg) && $stable(sum_reg))

endmodule

### design/cpd_out_stage.sv
// Result register of the deframer: holds one result until the receiver takes it.
// Depends on cpd_pkg.
module cpd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load_valid,
    input  cpd_pkg::result_t load_res,
    output logic             advance,
    output logic             tx_valid,
    input  logic             tx_stall,
    output cpd_pkg::result_t tx_res
);

    import cpd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // Move on when the register is empty or being emptied this cycle
    assign advance = !valid_reg || !tx_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= load_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_valid)
        begin
            res_reg <= load_res;
        end
    end

    assign tx_valid = valid_reg;
    assign tx_res   = res_reg;

endmodule

### design/checksummed_packet_deframer_unit.sv
// Checksummed packet deframer: fixed-length packets in, payload bytes out.
// Depends on cpd_pkg, cpd_in_stage, cpd_parser and cpd_out_stage.
//
// Usage:
//   The sender presents one packet byte per transaction on rx_byte with
//   rx_valid/rx_stall, starting at the low checksum byte. Each packet is
//   a 2-byte little-endian checksum, a 3-byte id, a 3-byte total and
//   DATA_BYTES payload bytes. Header bytes produce no result; each payload
//   byte produces one result transaction on tx_valid/tx_stall. The final
//   payload byte has is_last set and carries checksum_ok, packet_id and
//   packet_total; those fields are zero on the other bytes. A packet with
//   a bad checksum is still delivered; the receiver drops it.
//   An accepted byte passes through the input register, then the result
//   register. One byte per cycle is taken sustained while the receiver
//   does not stall; the sum update with end-around carry is combinational.
//   Reset returns to the start of a packet with all captured fields zero.
//   While the receiver stalls, the result holds; rx_stall rises once the
//   input register is also full, and no byte is lost.
module checksummed_packet_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        tx_valid,
    input  logic        tx_stall,
    output logic [7:0]  payload_byte,
    output logic        is_last,
    output logic        checksum_ok,
    output logic [23:0] packet_id,
    output logic [23:0] packet_total
);

    import cpd_pkg::*;

    logic       advance;
    logic       hold_valid;
    logic [7:0] hold_byte;
    logic       res_valid;
    result_t    res;
    result_t    tx_res;

    cpd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    cpd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (hold_valid && advance),
        .byte_in   (hold_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    cpd_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (hold_valid && res_valid),
        .load_res   (res),
        .advance    (advance),
        .tx_valid   (tx_valid),
        .tx_stall   (tx_stall),
        .tx_res     (tx_res)
    );

    assign payload_byte = tx_res.payload_byte;
    assign is_last      = tx_res.is_last;
    assign checksum_ok  = tx_res.checksum_ok;
    assign packet_id    = tx_res.packet_id;
    assign packet_total = tx_res.packet_total;

endmodule

### verif/testbench.sv
// Self-checking testbench for checksummed_packet_deframer_unit: packets are built and streamed
// byte by byte, and each payload result is checked against a local deframer model.
// Depends on cpd_pkg and the deframer RTL.
module testbench;
    import cpd_pkg::*;

    localparam int LIMIT      = 100000;
    localparam int RAND_ITEMS = 850;

    typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_SPARSE} fill_mode_t;
    typedef enum int {CK_GOOD, CK_BIT_FLIP, CK_RANDOM} cksum_mode_t;

    typedef struct {
        logic [15:0] ck;
        logic [23:0] id;
        logic [23:0] total;
        logic [7:0]  fill;
        logic        ok;
    } frame_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rx_valid = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        tx_valid;
    logic        tx_stall = 1'b0;
    logic [7:0]  payload_byte;
    logic        is_last;
    logic        checksum_ok;
    logic [23:0] packet_id;
    logic [23:0] packet_total;

    int          cycle_count = 0;
    int          err_count = 0;
    result_t     expected_bytes[$];
    logic [7:0]  frame_buf [PACKET_LEN];

    // Deframer state as seen from outside
    logic [POS_W-1:0] frame_pos = '0;
    logic [15:0]      ones_sum = '0;
    logic [15:0]      rx_cksum = '0;
    logic [23:0]      rx_id = '0;
    logic [23:0]      rx_total = '0;
    logic [7:0]       low_byte = '0;

    // Whole-packet cases whose outcome is plain: an all-zero packet sums to zero, so only
    // 0xFFFF matches; an all-ones packet sums to 0xFFFF, so 0x0000 matches.
    frame_row_t directed_frames [3] = '{
        '{ck: 16'hFFFF, id: 24'h000000, total: 24'h000000, fill: 8'h00, ok: 1'b1},
        '{ck: 16'h0000, id: 24'h000000, total: 24'h000000, fill: 8'h00, ok: 1'b0},
        '{ck: 16'h0000, id: 24'hFFFFFF, total: 24'hFFFFFF, fill: 8'hFF, ok: 1'b1}
    };

    checksummed_packet_deframer_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .rx_byte      (rx_byte),
        .tx_valid     (tx_valid),
        .tx_stall     (tx_stall),
        .payload_byte (payload_byte),
        .is_last      (is_last),
        .checksum_ok  (checksum_ok),
        .packet_id    (packet_id),
        .packet_total (packet_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic bit quiet_window();
        return cycle_count >= 2000 && cycle_count < 3200;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 50)
            $display("ERROR cycle %0d: %s", cycle_count, what);
    endtask

    // Advance the deframer state by one byte; return 1 when the byte yields a result.
    function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
        logic        at_end;
        logic        add_word;
        logic [15:0] word;
        logic [16:0] s;
        bit          in_header;
        at_end    = (int'(frame_pos) + 1 >= PACKET_LEN);
        in_header = (frame_pos < POS_PAYLOAD);
        add_word  = 1'b0;
        word      = '0;
        r         = '0;
        if (frame_pos == POS_CK_LO)
            rx_cksum = {8'h00, b};
        else if (frame_pos == POS_CK_HI)
            rx_cksum[15:8] = b;
        else
        begin
            // Words start at an even offset; an odd trailing byte goes in as the low half
            if (!frame_pos[0])
            begin
                low_byte = b;
                if (at_end)
                begin
                    add_word = 1'b1;
                    word     = {8'h00, b};
                end
            end
            else
            begin
                add_word = 1'b1;
                word     = {b, low_byte};
            end
            if (frame_pos <= POS_ID_LAST)
                rx_id = {rx_id[15:0], b};
            else if (frame_pos <= POS_TOT_LAST)
                rx_total = {rx_total[15:0], b};
        end
        if (add_word)
        begin
            s        = {1'b0, ones_sum} + {1'b0, word};
            ones_sum = s[15:0] + {15'd0, s[16]};
        end
        if (at_end)
        begin
            r.payload_byte = b;
            r.is_last      = 1'b1;
            r.checksum_ok  = ((~ones_sum) == rx_cksum);
            r.packet_id    = rx_id;
            r.packet_total = rx_total;
            frame_pos      = '0;
            ones_sum       = '0;
            return 1'b1;
        end
        frame_pos = frame_pos + 1'b1;
        if (in_header)
            return 1'b0;
        r.payload_byte = b;
        return 1'b1;
    endfunction

    task automatic load_header(input logic [15:0] ck, input logic [23:0] id,
                               input logic [23:0] total);
        frame_buf[0] = ck[7:0];
        frame_buf[1] = ck[15:8];
        frame_buf[2] = id[23:16];
        frame_buf[3] = id[15:8];
        frame_buf[4] = id[7:0];
        frame_buf[5] = total[23:16];
        frame_buf[6] = total[15:8];
        frame_buf[7] = total[7:0];
    endtask

    // Stream frame_buf; on a directed row the end-of-packet result comes from the row.
    task automatic send_frame(input bit typed_end, input frame_row_t row);
        result_t r;
        for (int i = 0; i < PACKET_LEN; i++)
        begin
            while (!quiet_window() && $urandom_range(99) < 17)
            begin
                rx_valid <= 1'b0;
                @(posedge clk);
            end
            rx_valid <= 1'b1;
            rx_byte  <= frame_buf[i];
            do
                @(posedge clk);
            while (rx_stall);
            if (deframe_byte(frame_buf[i], r))
            begin
                if (typed_end && r.is_last)
                    r = '{payload_byte: row.fill, is_last: 1'b1, checksum_ok: row.ok,
                          packet_id: row.id, packet_total: row.total};
                expected_bytes.push_back(r);
            end
        end
    endtask

    // Check each result transaction and drive the receiver stall
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && tx_valid && !tx_stall)
        begin
            got = {payload_byte, is_last, checksum_ok, packet_id, packet_total};
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("unexpected result byte=%h last=%b ok=%b id=%h tot=%h",
                    got.payload_byte, got.is_last, got.checksum_ok, got.packet_id,
                    got.packet_total));
            else
            begin
                want = expected_bytes.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "got byte=%h last=%b ok=%b id=%h tot=%h, want %h %b %b %h %h",
                        got.payload_byte, got.is_last, got.checksum_ok, got.packet_id,
                        got.packet_total, want.payload_byte, want.is_last,
                        want.checksum_ok, want.packet_id, want.packet_total));
            end
        end
        tx_stall <= !quiet_window() && ($urandom_range(99) < 17);
    end

    initial
    begin
        frame_row_t  no_row;
        fill_mode_t  fill_mode;
        cksum_mode_t ck_mode;
        int          rand_sent;
        int          pick;
        logic [31:0] acc;
        logic [15:0] word;
        logic [15:0] ck;
        no_row    = '{ck: '0, id: '0, total: '0, fill: '0, ok: 1'b0};
        rand_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_frames[r])
        begin
            load_header(directed_frames[r].ck, directed_frames[r].id, directed_frames[r].total);
            for (int i = HEADER_LEN; i < PACKET_LEN; i++)
                frame_buf[i] = directed_frames[r].fill;
            send_frame(1'b1, directed_frames[r]);
        end

        // Well-formed packets with random content; some carry a damaged checksum
        while (rand_sent < RAND_ITEMS)
        begin
            fill_mode = fill_mode_t'($urandom_range(2));
            load_header(16'h0000, 24'($urandom), 24'($urandom));
            for (int i = HEADER_LEN; i < PACKET_LEN; i++)
            begin
                case (fill_mode)
                    FILL_RANDOM:
                        frame_buf[i] = 8'($urandom);
                    FILL_EXTREME:
                    begin
                        pick = $urandom_range(3);
                        frame_buf[i] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF :
                                       (pick == 2) ? 8'h80 : 8'h7F;
                    end
                    default:
                        frame_buf[i] = ($urandom_range(15) == 0) ? 8'($urandom) : 8'h00;
                endcase
            end
            // Plain 32-bit sum, folded at the end
            acc = '0;
            for (int i = 2; i < PACKET_LEN; i += 2)
            begin
                word = (i + 1 < PACKET_LEN) ? {frame_buf[i+1], frame_buf[i]}
                                            : {8'h00, frame_buf[i]};
                acc  = acc + word;
            end
            acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
            acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
            ck  = ~acc[15:0];
            pick = $urandom_range(9);
            ck_mode = (pick < 6) ? CK_GOOD : (pick < 8) ? CK_BIT_FLIP : CK_RANDOM;
            case (ck_mode)
                CK_BIT_FLIP: ck = ck ^ (16'h0001 << $urandom_range(15));
                CK_RANDOM:   ck = 16'($urandom);
                default:     ck = ck;
            endcase
            frame_buf[0] = ck[7:0];
            frame_buf[1] = ck[15:8];
            send_frame(1'b0, no_row);
            rand_sent += PACKET_LEN;
        end

        rx_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

### checksummed_packet_deframer_unit.f
+incdir+design
design/cpd_pkg.sv
design/cpd_in_stage.sv
design/cpd_parser.sv
design/cpd_out_stage.sv
design/checksummed_packet_deframer_unit.sv
verif/testbench.sv
